[rtl/kufe_pkg.sv]
// Package for the union-find edge filter: sizes, table entry layout and
// controller states. No dependencies; the interfaces and the filter import it.
package kufe_pkg;

  // Node count of the forest and the derived table address width.
  localparam int NODES   = 131072;
  localparam int ADDR_W  = $clog2(NODES);

  // Fixed field widths of the channels.
  localparam int COST_W  = 32;
  localparam int NODE_W  = 17;
  localparam int TOTAL_W = 49;
  localparam int COUNT_W = 17;

  // Width used to compare a node index against the node count.
  localparam int RANGE_W = 21;

  // Each table entry carries an epoch tag; a tag that differs from the
  // current epoch marks the entry as "points at itself".
  localparam int EP_W    = 8;
  localparam int ENTRY_W = EP_W + ADDR_W;

  typedef struct packed {
    logic [EP_W-1:0]   epoch;
    logic [ADDR_W-1:0] parent;
  } kufe_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_FIND,
    ST_COMP,
    ST_NEXT,
    ST_LINK,
    ST_FIN
  } kufe_state_t;

endpackage

[rtl/kufe_if.sv]
// Valid/ready channel interfaces for edges in and filter results out.
// Depends on kufe_pkg for the field widths.
interface kufe_edge_if import kufe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] edge_cost;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic              start_new;

  modport source (output valid, edge_cost, node_a, node_b, start_new, input ready);
  modport sink   (input valid, edge_cost, node_a, node_b, start_new, output ready);
endinterface

interface kufe_result_if import kufe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [TOTAL_W-1:0] total_cost;
  logic [COUNT_W-1:0] accepted_count;

  modport source (output valid, accepted, total_cost, accepted_count, input ready);
  modport sink   (input valid, accepted, total_cost, accepted_count, output ready);
endinterface

[rtl/kufe_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module kufe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/kruskal_union_find_edge_filter.sv]
// Kruskal edge filter: union-find forest in one table RAM, path-compressing
// finds, running cost total. Depends on kufe_pkg, kufe_if.sv, kufe_ram.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------
//  in_edge  | in  | valid/ready          | edge_cost, node_a, node_b, start_new
//  out_res  | out | valid/ready          | accepted, total_cost, accepted_count
//
// Sequencing: one transaction at a time. An accepted edge passes through
//   START, then FIND (with COMP when path compression applies) and NEXT for
//   each endpoint, then LINK and FIN; each parent hop walked and each node
//   rewritten costs its own access, as the parent table has one read port.
// Reset: a clearing pass over all NODES entries tags every table entry stale; the
//   same pass runs again on every 255th start_new (epoch tag wrap).
// Stalls: a finished result waits in the output register; the next edge is
//   taken meanwhile and held in the final state only if the register is full.
module kruskal_union_find_edge_filter import kufe_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  kufe_edge_if.sink       in_edge,
  kufe_result_if.source   out_res
);

  // Table RAM ports.
  logic              we;
  logic [ADDR_W-1:0] waddr;
  kufe_entry_t       wdata;
  logic [ADDR_W-1:0] raddr;
  kufe_entry_t       rdata;

  kufe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  kufe_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0]  cur_r, cur_nxt;        // address whose entry is being read
  logic [ADDR_W-1:0]  root_r, root_nxt;      // root of the endpoint just walked
  logic [ADDR_W-1:0]  root_a_r, root_a_nxt;  // root of node_a
  logic               side_r, side_nxt;      // 0: walking node_a, 1: node_b
  logic [COST_W-1:0]  cost_r, cost_nxt;
  logic [NODE_W-1:0]  node_a_r, node_a_nxt;
  logic [NODE_W-1:0]  node_b_r, node_b_nxt;
  logic               acc_r, acc_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [EP_W-1:0]    epoch_r, epoch_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic               pend_r, pend_nxt;      // edge waits behind a clearing pass

  logic               out_valid_r, out_valid_nxt;
  logic               out_acc_r, out_acc_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic [ADDR_W-1:0]  eff_parent;  // parent of cur_r; stale entries point at themselves
  logic [ADDR_W-1:0]  addr_a, addr_b, start_node;
  logic               in_range;
  logic [TOTAL_W:0]   sum;

  assign eff_parent = (rdata.epoch == epoch_r) ? rdata.parent : cur_r;
  assign addr_a     = ADDR_W'(node_a_r);
  assign addr_b     = ADDR_W'(node_b_r);
  assign start_node = side_r ? addr_b : addr_a;
  assign in_range   = (RANGE_W'(node_a_r) < RANGE_W'(NODES)) &&
                      (RANGE_W'(node_b_r) < RANGE_W'(NODES));
  assign sum        = {1'b0, total_r} + (TOTAL_W + 1)'(cost_r);

  assign in_edge.ready          = (state_r == ST_IDLE);
  assign out_res.valid          = out_valid_r;
  assign out_res.accepted       = out_acc_r;
  assign out_res.total_cost     = out_total_r;
  assign out_res.accepted_count = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      epoch_r     <= EP_W'(1);
      clr_r       <= '0;
      pend_r      <= 1'b0;
      total_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    root_r      <= root_nxt;
    root_a_r    <= root_a_nxt;
    side_r      <= side_nxt;
    cost_r      <= cost_nxt;
    node_a_r    <= node_a_nxt;
    node_b_r    <= node_b_nxt;
    acc_r       <= acc_nxt;
    out_acc_r   <= out_acc_nxt;
    out_total_r <= out_total_nxt;
    out_count_r <= out_count_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    root_a_nxt    = root_a_r;
    side_nxt      = side_r;
    cost_nxt      = cost_r;
    node_a_nxt    = node_a_r;
    node_b_nxt    = node_b_r;
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    count_nxt     = count_r;
    epoch_nxt     = epoch_r;
    clr_nxt       = clr_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_acc_nxt   = out_acc_r;
    out_total_nxt = out_total_r;
    out_count_nxt = out_count_r;
    we            = 1'b0;
    waddr         = cur_r;
    wdata         = '{epoch: epoch_r, parent: root_r};
    raddr         = cur_r;

    unique case (state_r)
      ST_CLEAR: begin
        // Sweep the table with epoch zero, which never matches a live epoch.
        we    = 1'b1;
        waddr = clr_r;
        wdata = '{epoch: '0, parent: '0};
        if (clr_r == ADDR_W'(NODES - 1)) begin
          clr_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? ST_START : ST_IDLE;
        end else begin
          clr_nxt = clr_r + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_edge.valid) begin
          cost_nxt   = in_edge.edge_cost;
          node_a_nxt = in_edge.node_a;
          node_b_nxt = in_edge.node_b;
          state_nxt  = ST_START;
          if (in_edge.start_new) begin
            // New graph: bump the epoch so every entry reads as identity.
            total_nxt = '0;
            count_nxt = '0;
            if (epoch_r == '1) begin
              epoch_nxt = EP_W'(1);
              pend_nxt  = 1'b1;
              state_nxt = ST_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EP_W'(1);
            end
          end
        end
      end

      ST_START: begin
        acc_nxt  = 1'b0;
        side_nxt = 1'b0;
        if (in_range) begin
          raddr     = addr_a;
          cur_nxt   = addr_a;
          state_nxt = ST_FIND;
        end else begin
          // Out-of-range node: reject, leave the forest alone.
          state_nxt = ST_FIN;
        end
      end

      ST_FIND: begin
        if (eff_parent == cur_r) begin
          root_nxt = cur_r;
          if (start_node == cur_r) begin
            state_nxt = ST_NEXT;
          end else begin
            // Walk the chain again, pointing each node at the root.
            raddr     = start_node;
            cur_nxt   = start_node;
            state_nxt = ST_COMP;
          end
        end else begin
          raddr   = eff_parent;
          cur_nxt = eff_parent;
        end
      end

      ST_COMP: begin
        we    = 1'b1;
        waddr = cur_r;
        wdata = '{epoch: epoch_r, parent: root_r};
        if (eff_parent == root_r) begin
          state_nxt = ST_NEXT;
        end else begin
          raddr   = eff_parent;
          cur_nxt = eff_parent;
        end
      end

      ST_NEXT: begin
        if (!side_r) begin
          root_a_nxt = root_r;
          side_nxt   = 1'b1;
          raddr      = addr_b;
          cur_nxt    = addr_b;
          state_nxt  = ST_FIND;
        end else begin
          state_nxt = ST_LINK;
        end
      end

      ST_LINK: begin
        if (root_a_r != root_r) begin
          // Separate components: hang the larger root under the smaller.
          acc_nxt = 1'b1;
          we      = 1'b1;
          if (root_a_r < root_r) begin
            waddr = root_r;
            wdata = '{epoch: epoch_r, parent: root_a_r};
          end else begin
            waddr = root_a_r;
            wdata = '{epoch: epoch_r, parent: root_r};
          end
          total_nxt = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
          if (count_r != '1) begin
            count_nxt = count_r + COUNT_W'(1);
          end
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // Hold until the output register is free or being drained.
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc_r;
          out_total_nxt = total_r;
          out_count_nxt = count_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
